// ===== design/gcsf_pkg.sv =====
package gcsf_pkg;

	// list capacity and derived widths
	localparam int MAX_STOPS = 16;
	localparam int IDX_W = $clog2(MAX_STOPS);
	localparam int CNT_W = $clog2(MAX_STOPS + 1);

	// divider widths: dividend is a magnitude scaled by up to 2^16
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DSR_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// divide by 100 as multiply by 2^37/100 rounded up, then shift, exact for 32-bit magnitudes
	localparam logic [31:0] PCT_RECIP = 32'h51eb_851f;
	localparam int PCT_SHIFT = 37;

	// position kinds
	localparam logic [1:0] KIND_UNSET = 2'd0;
	localparam logic [1:0] KIND_PERCENT = 2'd1;
	localparam logic [1:0] KIND_LENGTH = 2'd2;

	typedef struct packed {
		logic [1:0] stop_kind;
		logic signed [31:0] stop_value;
		logic [31:0] stop_color;
		logic last_stop;
	} stop_in_t;

	typedef struct packed {
		logic [31:0] out_color;
		logic signed [31:0] out_position;
		logic out_last;
		logic out_dropped;
	} stop_out_t;

	// word between front and back
	typedef struct packed {
		logic store;
		logic last;
		logic dropped;
		logic known;
		logic signed [31:0] pos;
		logic [31:0] color;
	} entry_t;

	typedef struct packed {
		logic known;
		logic signed [31:0] pos;
		logic [31:0] color;
	} mem_word_t;

	localparam int MEM_W = $bits(mem_word_t);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_MUL
	} front_state_t;

	typedef enum logic [2:0] {
		B_LOAD,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_INT_RD,
		B_INT_WAIT,
		B_EMIT_B
	} back_state_t;

	// signed saturation of a sign and magnitude quotient
	function automatic logic signed [31:0] sat_q16(input logic neg,
			input logic [DIV_DVD_W-1:0] q);
		logic signed [31:0] r;
		if (neg) begin
			if (q > DIV_DVD_W'(33'h0_8000_0000))
				r = Q_MIN;
			else
				r = -$signed(q[31:0]);
		end else begin
			if (q > DIV_DVD_W'(32'h7fff_ffff))
				r = Q_MAX;
			else
				r = $signed(q[31:0]);
		end
		return r;
	endfunction

endpackage

// ===== design/gcsf_ram.sv =====
module gcsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== design/gcsf_div.sv =====
module gcsf_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [gcsf_pkg::DIV_DVD_W-1:0] dividend,
	input logic [gcsf_pkg::DIV_DSR_W-1:0] divisor,
	output logic done,
	output logic [gcsf_pkg::DIV_DVD_W-1:0] quotient
);
	import gcsf_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W:0] trial;
	logic [DIV_DSR_W:0] diff;
	logic ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

// ===== design/gcsf_front.sv =====
module gcsf_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input gcsf_pkg::stop_in_t item,
	input logic [30:0] line_length,
	input logic fifo_full,
	output logic busy,
	output logic push,
	output gcsf_pkg::entry_t push_entry
);
	import gcsf_pkg::*;

	front_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic signed [31:0] rmax_q;
	logic dropped_q;
	logic neg_q, first_q, last_q;
	logic [31:0] color_q;
	logic [63:0] pct_prod_q;

	logic accept, store, is_pct, is_len, needs_div;
	logic [31:0] mag;
	logic div_start, div_done;
	logic [DIV_DVD_W-1:0] div_dividend, div_q;
	logic [DIV_DSR_W-1:0] div_divisor;

	logic fin_known, fin_first, fin_last;
	logic signed [31:0] fin_raw, fin_pos, fin_rmax, fin_unset_last;
	logic fin_known_o;

	assign busy = (state_q != F_IDLE) || fifo_full;
	assign accept = start && !busy;
	assign store = count_q < CNT_W'(MAX_STOPS);
	assign is_pct = item.stop_kind == KIND_PERCENT;
	assign is_len = (item.stop_kind == KIND_LENGTH) && (line_length != '0);
	assign needs_div = is_pct || is_len;
	assign mag = item.stop_value[31] ? 32'(-item.stop_value) : item.stop_value;

	// divider operands, length stops only
	assign div_dividend = {mag, 16'h0000};
	assign div_divisor = DIV_DSR_W'(line_length);
	assign div_start = accept && store && is_len;

	gcsf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_q)
	);

	// position fixup against the running maximum
	assign fin_unset_last = (rmax_q > Q_ONE) ? rmax_q : Q_ONE;
	always_comb begin
		fin_pos = '0;
		fin_known_o = fin_known;
		fin_rmax = rmax_q;
		if (fin_first) begin
			fin_known_o = 1'b1;
			fin_pos = fin_known ? fin_raw : '0;
			fin_rmax = fin_pos;
		end else if (fin_known) begin
			fin_pos = (fin_raw < rmax_q) ? rmax_q : fin_raw;
			fin_rmax = fin_pos;
		end else if (fin_last) begin
			fin_known_o = 1'b1;
			fin_pos = fin_unset_last;
		end
	end

	// select source of the finished stop
	always_comb begin
		state_d = state_q;
		push = 1'b0;
		fin_known = 1'b0;
		fin_raw = '0;
		fin_first = count_q == '0;
		fin_last = item.last_stop;
		push_entry = '0;
		push_entry.color = item.stop_color;
		push_entry.dropped = dropped_q;
		case (state_q)
			F_IDLE: begin
				fin_known = item.stop_kind == KIND_LENGTH;
				if (accept) begin
					if (!store) begin
						push = item.last_stop;
						push_entry.store = 1'b0;
						push_entry.last = 1'b1;
						push_entry.dropped = 1'b1;
						push_entry.known = 1'b1;
						push_entry.pos = fin_unset_last;
					end else if (needs_div) begin
						state_d = is_pct ? F_MUL : F_DIV;
					end else begin
						push = 1'b1;
						push_entry.store = 1'b1;
						push_entry.last = item.last_stop;
						push_entry.known = fin_known_o;
						push_entry.pos = fin_pos;
					end
				end
			end
			F_DIV: begin
				fin_known = 1'b1;
				fin_raw = sat_q16(neg_q, div_q);
				fin_first = first_q;
				fin_last = last_q;
				push_entry.color = color_q;
				if (div_done) begin
					push = 1'b1;
					push_entry.store = 1'b1;
					push_entry.last = last_q;
					push_entry.known = fin_known_o;
					push_entry.pos = fin_pos;
					state_d = F_IDLE;
				end
			end
			F_MUL: begin
				fin_known = 1'b1;
				fin_raw = sat_q16(neg_q, DIV_DVD_W'(pct_prod_q[63:PCT_SHIFT]));
				fin_first = first_q;
				fin_last = last_q;
				push_entry.color = color_q;
				push = 1'b1;
				push_entry.store = 1'b1;
				push_entry.last = last_q;
				push_entry.known = fin_known_o;
				push_entry.pos = fin_pos;
				state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rmax_q <= '0;
			dropped_q <= 1'b0;
		end else if (push && push_entry.last) begin
			count_q <= '0;
			rmax_q <= '0;
			dropped_q <= 1'b0;
		end else if (push) begin
			count_q <= count_q + 1'b1;
			rmax_q <= fin_rmax;
		end else if (accept && !store) begin
			dropped_q <= 1'b1;
		end
	end

	// held stop while dividing or scaling a percentage
	always_ff @(posedge clk) begin
		if (accept && store && needs_div) begin
			neg_q <= item.stop_value[31];
			first_q <= count_q == '0;
			last_q <= item.last_stop;
			color_q <= item.stop_color;
			pct_prod_q <= 64'(mag) * 64'(PCT_RECIP);
		end
	end

endmodule

// ===== design/gcsf_fifo.sv =====
module gcsf_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input gcsf_pkg::entry_t push_entry,
	output logic full,
	output logic valid,
	input logic pop,
	output gcsf_pkg::entry_t head
);
	import gcsf_pkg::*;

	entry_t slot_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_entry;
	end

endmodule

// ===== design/gcsf_back.sv =====
module gcsf_back (
	input logic clk,
	input logic arst_n,
	input logic fifo_valid,
	input gcsf_pkg::entry_t fifo_head,
	output logic pop,
	output logic strobe,
	output gcsf_pkg::stop_out_t result
);
	import gcsf_pkg::*;

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, n_q;
	logic last_known_q, dropped_q;
	logic [31:0] last_color_q, b_color_q;
	logic [IDX_W-1:0] a_idx_q, b_idx_q, i_q, k_q;
	logic signed [31:0] a_pos_q, b_pos_q;
	logic strobe_q;
	stop_out_t result_q;

	logic we;
	logic [IDX_W-1:0] waddr, raddr, span;
	mem_word_t wdata, rdata;
	logic [MEM_W-1:0] rdata_raw;

	logic emit, emit_last;
	logic [31:0] emit_color;
	logic signed [31:0] emit_pos;

	logic div_start, div_done;
	logic [DIV_DVD_W-1:0] div_dividend, div_q;
	logic [31:0] gap;

	gcsf_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_STOPS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);
	assign rdata = mem_word_t'(rdata_raw);

	// interior stop: base + gap * k / span
	assign span = b_idx_q - a_idx_q;
	assign gap = 32'(b_pos_q - a_pos_q);
	assign div_dividend = DIV_DVD_W'(gap) * DIV_DVD_W'(k_q);
	assign div_start = state_q == B_INT_RD;

	gcsf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(DIV_DSR_W'(span)),
		.done(div_done),
		.quotient(div_q)
	);

	assign raddr = (state_q == B_INT_RD || state_q == B_INT_WAIT) ? a_idx_q + k_q : i_q;

	// load, scan and emit sequencer
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		we = 1'b0;
		waddr = cnt_q[IDX_W-1:0];
		wdata = {fifo_head.known, fifo_head.pos, fifo_head.color};
		emit = 1'b0;
		emit_last = 1'b0;
		emit_color = rdata.color;
		emit_pos = rdata.pos;
		case (state_q)
			B_LOAD: begin
				pop = fifo_valid;
				if (fifo_valid) begin
					if (fifo_head.store) begin
						we = 1'b1;
					end else if (!last_known_q) begin
						we = fifo_head.last;
						waddr = IDX_W'(cnt_q - 1'b1);
						wdata = {1'b1, fifo_head.pos, last_color_q};
					end
					if (fifo_head.last)
						state_d = B_SCAN_RD;
				end
			end
			B_SCAN_RD: state_d = B_SCAN_CHK;
			B_SCAN_CHK: begin
				if (i_q == '0) begin
					emit = 1'b1;
					emit_last = n_q == CNT_W'(1);
					state_d = emit_last ? B_LOAD : B_SCAN_RD;
				end else if (rdata.known) begin
					state_d = (i_q - a_idx_q == IDX_W'(1)) ? B_EMIT_B : B_INT_RD;
				end else begin
					state_d = B_SCAN_RD;
				end
			end
			B_INT_RD: state_d = B_INT_WAIT;
			B_INT_WAIT: begin
				if (div_done) begin
					emit = 1'b1;
					emit_pos = a_pos_q + $signed(div_q[31:0]);
					state_d = (k_q + 1'b1 == span) ? B_EMIT_B : B_INT_RD;
				end
			end
			B_EMIT_B: begin
				emit = 1'b1;
				emit_color = b_color_q;
				emit_pos = b_pos_q;
				emit_last = CNT_W'(b_idx_q) + 1'b1 == n_q;
				state_d = emit_last ? B_LOAD : B_SCAN_RD;
			end
			default: state_d = B_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			last_known_q <= 1'b0;
			dropped_q <= 1'b0;
			strobe_q <= 1'b0;
			i_q <= '0;
			k_q <= '0;
			a_idx_q <= '0;
			b_idx_q <= '0;
		end else begin
			state_q <= state_d;
			strobe_q <= emit;
			// list fill
			if (state_q == B_LOAD && fifo_valid) begin
				if (fifo_head.store) begin
					last_known_q <= fifo_head.known;
				end
				if (fifo_head.last) begin
					n_q <= cnt_q + CNT_W'(fifo_head.store);
					dropped_q <= fifo_head.dropped;
					cnt_q <= '0;
					i_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(fifo_head.store);
				end
			end
			// scan for the next known stop
			if (state_q == B_SCAN_CHK) begin
				if (i_q == '0) begin
					a_idx_q <= '0;
					i_q <= IDX_W'(1);
				end else if (rdata.known) begin
					b_idx_q <= i_q;
					k_q <= IDX_W'(1);
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (state_q == B_INT_WAIT && div_done)
				k_q <= k_q + 1'b1;
			if (state_q == B_EMIT_B) begin
				a_idx_q <= b_idx_q;
				i_q <= b_idx_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && fifo_valid && fifo_head.store)
			last_color_q <= fifo_head.color;
		if (state_q == B_SCAN_CHK) begin
			if (i_q == '0)
				a_pos_q <= rdata.pos;
			b_pos_q <= rdata.pos;
			b_color_q <= rdata.color;
		end
		if (state_q == B_EMIT_B)
			a_pos_q <= b_pos_q;
		if (emit) begin
			result_q.out_color <= emit_color;
			result_q.out_position <= emit_pos;
			result_q.out_last <= emit_last;
			result_q.out_dropped <= dropped_q;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== design/gradient_color_stop_fixup_core.sv =====
// Gradient color stop fixup. Stops are written one word per start pulse; a
// stop whose position is unset or a length on a zero-length line is pushed as
// it is accepted, a percentage goes through a reciprocal multiply and then
// fixup, and a length position waits on the 48-step bit-serial divider in the
// front end. On the word that carries last_stop the back end replays the stored
// list and puts out one result word per stop on strobe, each for one cycle with
// no way to hold it: the first stop after a read and check, each later known
// stop after a read, a check and an emit state, and each interpolated stop
// after a read state and one 48-step divide. The front end keeps taking the
// next list during emission until its two-word queue fills. Stops beyond 16
// in a list are dropped and out_dropped is set on that list.
module gradient_color_stop_fixup_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input gcsf_pkg::stop_in_t item,
	output logic busy,
	input logic cfg_we,
	input logic [30:0] cfg_data,
	output logic strobe,
	output gcsf_pkg::stop_out_t result
);
	import gcsf_pkg::*;

	logic [30:0] line_length_q;
	logic push, fifo_full, fifo_valid, pop;
	entry_t push_entry, fifo_head;

	// line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_length_q <= '0;
		else if (cfg_we)
			line_length_q <= cfg_data;
	end

	gcsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.line_length(line_length_q),
		.fifo_full(fifo_full),
		.busy(busy),
		.push(push),
		.push_entry(push_entry)
	);

	gcsf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(fifo_full),
		.valid(fifo_valid),
		.pop(pop),
		.head(fifo_head)
	);

	gcsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fifo_valid(fifo_valid),
		.fifo_head(fifo_head),
		.pop(pop),
		.strobe(strobe),
		.result(result)
	);

endmodule

// ===== tb/sv/gradient_color_stop_fixup_core_tb.sv =====
`timescale 1ns / 1ps

module gradient_color_stop_fixup_core_tb;
	import gcsf_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	stop_in_t item;
	logic busy;
	logic cfg_we;
	logic [30:0] cfg_data;
	logic strobe;
	stop_out_t result;

	gradient_color_stop_fixup_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.result(result)
	);

	// predictor state
	logic [30:0] line_len;
	logic [31:0] stored_color [MAX_STOPS];
	logic signed [31:0] stored_pos [MAX_STOPS];
	logic stored_known [MAX_STOPS];
	int stored_count;
	logic signed [31:0] pos_max;
	logic lost_stops;

	stop_in_t pending_words[$];
	stop_out_t expected_stops[$];
	int errors;
	int words_sent;
	int stops_seen;
	int gap_pct;
	bit hold_off;

	// resolve one position to a line fraction
	function automatic logic signed [31:0] resolve_pos(stop_in_t w, output bit known);
		longint v;
		longint q;
		v = longint'(w.stop_value);
		known = 1;
		if (w.stop_kind == KIND_PERCENT)
			return 32'(v / 100);
		if (w.stop_kind == KIND_LENGTH) begin
			if (line_len == 0)
				return 32'sd0;
			q = (v * 65536) / longint'({33'd0, line_len});
			if (q > 64'sd2147483647) return Q_MAX;
			if (q < -64'sd2147483648) return Q_MIN;
			return 32'(q);
		end
		known = 0;
		return 32'sd0;
	endfunction

	// fold one accepted word into the stop list, emit on last
	task automatic predict_stops(stop_in_t w);
		bit known;
		logic signed [31:0] p;
		int a;
		int span;
		longint base;
		longint unsigned diff;
		stop_out_t r;
		if (stored_count < MAX_STOPS) begin
			p = resolve_pos(w, known);
			if (stored_count == 0) begin
				if (!known) begin
					p = 0;
					known = 1;
				end
				pos_max = p;
			end else if (known) begin
				if (p < pos_max) p = pos_max;
				pos_max = p;
			end
			stored_color[stored_count] = w.stop_color;
			stored_pos[stored_count] = known ? p : 32'sd0;
			stored_known[stored_count] = known;
			stored_count++;
		end else
			lost_stops = 1;
		if (!w.last_stop)
			return;
		if (!stored_known[stored_count-1]) begin
			stored_pos[stored_count-1] = pos_max > Q_ONE ? pos_max : Q_ONE;
			stored_known[stored_count-1] = 1;
		end
		a = 0;
		for (int i = 1; i < stored_count; i++) begin
			if (stored_known[i]) begin
				span = i - a;
				base = longint'(stored_pos[a]);
				diff = longint'(stored_pos[i]) - base;
				for (int k = 1; k < span; k++) begin
					stored_pos[a+k] = 32'(base + longint'((diff * k) / span));
					stored_known[a+k] = 1;
				end
				a = i;
			end
		end
		for (int i = 0; i < stored_count; i++) begin
			r.out_color = stored_color[i];
			r.out_position = stored_pos[i];
			r.out_last = (i == stored_count - 1);
			r.out_dropped = lost_stops;
			expected_stops = {expected_stops, r};
		end
		stored_count = 0;
		pos_max = 0;
		lost_stops = 0;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// random stop word
	function automatic stop_in_t rand_stop(bit last, int mode);
		stop_in_t w;
		int r;
		w.stop_kind = 2'($urandom_range(0, 3));
		w.stop_color = $urandom;
		w.last_stop = last;
		r = $urandom_range(0, 9);
		if (r < 2)
			w.stop_value = $urandom;
		else if (r < 3)
			w.stop_value = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
		else
			w.stop_value = 32'($urandom_range(0, 120 << 16)) - (mode ? 32'(10 << 16) : 0);
		return w;
	endfunction

	task automatic queue_list(int n);
		for (int i = 0; i < n; i++)
			pending_words = {pending_words, rand_stop(i == n - 1, $urandom_range(0, 1))};
	endtask

	function automatic stop_in_t mk(logic [1:0] k, logic [31:0] v, logic [31:0] c, bit l);
		stop_in_t w;
		w.stop_kind = k;
		w.stop_value = v;
		w.stop_color = c;
		w.last_stop = l;
		return w;
	endfunction

	// wait until the block is idle, then write the line length
	task automatic set_line_length(logic [30:0] v);
		while (pending_words.size() != 0 || expected_stops.size() != 0 || busy)
			@(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		line_len = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && !hold_off && pending_words.size() != 0 &&
				($urandom_range(0, 99) >= gap_pct)) begin
			item <= pending_words[0];
			start <= 1;
		end else
			start <= 0;
	end

	// acceptance and result check at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			predict_stops(item);
			void'(pending_words.pop_front());
			words_sent++;
		end
		if (arst_n && strobe) begin
			stops_seen++;
			if (expected_stops.size() == 0) begin
				report_mismatch("unexpected stop word", result.out_color, 32'd0);
			end else begin
				if (result.out_color !== expected_stops[0].out_color)
					report_mismatch("color", result.out_color, expected_stops[0].out_color);
				if (result.out_position !== expected_stops[0].out_position)
					report_mismatch("position", result.out_position,
						expected_stops[0].out_position);
				if (result.out_last !== expected_stops[0].out_last)
					report_mismatch("last", 32'(result.out_last),
						32'(expected_stops[0].out_last));
				if (result.out_dropped !== expected_stops[0].out_dropped)
					report_mismatch("dropped", 32'(result.out_dropped),
						32'(expected_stops[0].out_dropped));
				void'(expected_stops.pop_front());
			end
		end
	end

	// stimulus
	initial begin
		errors = 0;
		words_sent = 0;
		stops_seen = 0;
		stored_count = 0;
		pos_max = 0;
		lost_stops = 0;
		line_len = 0;
		gap_pct = 6;
		hold_off = 0;
		start = 0;
		item = '0;
		cfg_we = 0;
		cfg_data = '0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// zero line length: length stops resolve to zero
		pending_words = {pending_words, mk(KIND_LENGTH, 32'sh0064_0000, 32'hffff_ffff, 1)};
		pending_words = {pending_words, mk(KIND_UNSET, 32'h1234_0000, 32'h0000_0000, 0)};
		pending_words = {pending_words, mk(2'd3, 32'h0, 32'h1111_1111, 0)};
		pending_words = {pending_words, mk(KIND_PERCENT, 32'sh0032_0000, 32'h2222_2222, 0)};
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MAX, 32'h3333_3333, 1)};
		set_line_length(31'h0001_0000);
		// first stop negative, later stop lower than max, saturated lengths
		pending_words = {pending_words, mk(KIND_PERCENT, Q_MIN, 32'h4444_4444, 0)};
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MAX, 32'h5555_5555, 0)};
		pending_words = {pending_words, mk(KIND_PERCENT, 32'sh0019_0000, 32'h6666_6666, 0)};
		pending_words = {pending_words, mk(KIND_UNSET, 32'h0, 32'h7777_7777, 0)};
		pending_words = {pending_words, mk(KIND_UNSET, 32'h0, 32'h8888_8888, 1)};
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MIN, 32'h9999_9999, 1)};
		// overflow: 18 stops, last two dropped
		for (int i = 0; i < 18; i++)
			pending_words = {pending_words, mk(KIND_UNSET, 32'h0, 32'(i), i == 17)};
		set_line_length(31'h7fff_ffff);
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MAX, 32'habcd_ef01, 0)};
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MIN, 32'h1020_3040, 1)};
		set_line_length(31'd1);
		pending_words = {pending_words, mk(KIND_LENGTH, 32'sh0000_0001, 32'h0f0f_0f0f, 0)};
		pending_words = {pending_words, mk(KIND_LENGTH, Q_MIN, 32'hf0f0_f0f0, 1)};

		// random lists, three idling phases and three line lengths
		for (int ph = 0; ph < 3; ph++) begin
			set_line_length(ph == 0 ? 31'($urandom_range(1 << 16, 400 << 16)) :
				ph == 1 ? 31'($urandom) : 31'($urandom_range(1, 255)));
			gap_pct = ph == 0 ? 6 : ph == 1 ? 72 : 0;
			for (int l = 0; l < 6; l++)
				queue_list($urandom_range(0, 9) == 0 ? $urandom_range(16, 19) :
					$urandom_range(1, 5));
			// sender holds off until every expected stop has arrived
			while (pending_words.size() != 0) @(posedge clk);
			@(negedge clk);
			hold_off = 1;
			while (expected_stops.size() != 0 || busy) @(posedge clk);
			@(negedge clk);
			hold_off = 0;
			for (int l = 0; l < 4; l++)
				queue_list($urandom_range(1, 4));
		end

		while (pending_words.size() != 0 || expected_stops.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d stop words, checked %0d emitted stops", words_sent, stops_seen);
		$display("covered zero, minimal, mid and full line lengths, overflowing lists");
		if (errors == 0 && expected_stops.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
